>>> design/cfd_pkg.sv
// cfd_pkg: constants and the stream header table for the channel frame deframer
// depends on nothing; used by channel_frame_deframer
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    // number of stream header bytes checked after reset (1 to 16)
    localparam int HDR_BYTES = 12;
    localparam int HDR_IDX_W = 4;
    // header index value at which the header is complete (index wraps at 16)
    localparam logic [HDR_IDX_W-1:0] HDR_END = HDR_IDX_W'(HDR_BYTES % 16);

    localparam int BYTE_W = 8;
    localparam int CHAN_W = 16;
    localparam int LEN_W  = 16;
    localparam int OUT_DATA_W = BYTE_W + CHAN_W;
    localparam int OUT_USER_W = 2;

    // tuser bit positions
    localparam int USER_CTRL = 0;
    localparam int USER_HERR = 1;

    // expected header text, zero past the default text
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = 8'h58;
            4'd1:    b = 8'h7A;
            4'd2:    b = 8'h20;
            4'd3:    b = 8'h30;
            4'd4:    b = 8'h30;
            4'd5:    b = 8'h30;
            4'd6:    b = 8'h2E;
            4'd7:    b = 8'h30;
            4'd8:    b = 8'h30;
            4'd9:    b = 8'h31;
            4'd10:   b = 8'h0D;
            4'd11:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> design/channel_frame_deframer.sv
// channel_frame_deframer: throughput one byte per cycle while no waiting result holds a byte
// that emits; an input register feeds the phase logic, which loads a result register that
// drives m_*; while a result waits on m_tready only bytes that emit nothing move on.
// aresetn is synchronous, active low: phase returns to header check, counters clear,
// both pipeline registers empty. after a header mismatch every byte is dropped until reset.
// depends on cfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module channel_frame_deframer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cfd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cfd_pkg::OUT_DATA_W-1:0]      m_tdata,   // [7:0] payload_byte, [23:8] frame_channel
    output logic                                m_tlast,   // end_of_frame
    output logic [cfd_pkg::OUT_USER_W-1:0]      m_tuser    // [0] is_control, [1] header_error
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_CH_LO   = 3'd1;
    localparam logic [2:0] PH_CH_HI   = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_LEN_HI  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_HALTED  = 3'd6;

    // input stage
    logic                           in_valid_reg;
    logic [cfd_pkg::BYTE_W-1:0]     in_byte_reg;

    // deframer state
    logic [2:0]                     phase_reg, phase_next;
    logic [cfd_pkg::HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [cfd_pkg::CHAN_W-1:0]     chan_reg, chan_next;
    logic [cfd_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [cfd_pkg::LEN_W-1:0]      count_reg, count_next;

    // result register
    logic                           out_valid_reg;
    logic [cfd_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;
    logic [cfd_pkg::OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic                           emit;
    logic                           out_free;
    logic                           advance;
    logic [cfd_pkg::LEN_W-1:0]      count_inc;

    assign count_inc = count_reg + cfd_pkg::LEN_W'(1);

    always_comb begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        chan_next     = chan_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        out_data_next = '0;
        out_last_next = 1'b0;
        out_user_next = '0;
        case (phase_reg)
            PH_HEADER: begin
                if (in_byte_reg != cfd_pkg::hdr_byte(hdr_idx_reg)) begin
                    phase_next = PH_HALTED;
                    emit       = 1'b1;
                    out_user_next[cfd_pkg::USER_HERR] = 1'b1;
                end else begin
                    hdr_idx_next = hdr_idx_reg + cfd_pkg::HDR_IDX_W'(1);
                    if (hdr_idx_next == cfd_pkg::HDR_END) begin
                        phase_next = PH_CH_LO;
                    end
                end
            end
            PH_CH_LO: begin
                chan_next  = {{(cfd_pkg::CHAN_W-cfd_pkg::BYTE_W){1'b0}}, in_byte_reg};
                phase_next = PH_CH_HI;
            end
            PH_CH_HI: begin
                chan_next  = {in_byte_reg, chan_reg[cfd_pkg::BYTE_W-1:0]};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next   = {{(cfd_pkg::LEN_W-cfd_pkg::BYTE_W){1'b0}}, in_byte_reg};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next   = {in_byte_reg, len_reg[cfd_pkg::BYTE_W-1:0]};
                count_next = '0;
                // zero-length frame ends here with no result
                phase_next = (len_next == '0) ? PH_CH_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                emit          = 1'b1;
                out_data_next = {chan_reg, in_byte_reg};
                out_user_next[cfd_pkg::USER_CTRL] = (chan_reg == '0);
                if (count_inc == len_reg) begin
                    out_last_next = 1'b1;
                    count_next    = '0;
                    phase_next    = PH_CH_LO;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_HALTED: begin
                phase_next = PH_HALTED;
            end
            default: begin
                phase_next = PH_HALTED;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    // a beat with no result retires even while the result register is full
    assign advance  = in_valid_reg && (out_free || !emit);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= '0;
            chan_reg    <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            chan_reg    <= chan_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && emit) begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // only header check and payload phases ever load a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |-> (phase_reg == PH_HEADER || phase_reg == PH_PAYLOAD))
        else $error("result from a phase that emits nothing");

    // an error result leaves the block halted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[cfd_pkg::USER_HERR]) |-> (phase_reg == PH_HALTED))
        else $error("header error without halt");

    // the byte count never reaches the frame length inside a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < len_reg))
        else $error("payload count overran frame length");

    // an error beat carries no frame marks
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[cfd_pkg::USER_HERR]) |->
            (!m_tlast && !m_tuser[cfd_pkg::USER_CTRL] && m_tdata == '0))
        else $error("error beat with frame fields set");

    // once halted, the block stays halted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALTED) |=> (phase_reg == PH_HALTED))
        else $error("left halted phase without reset");

endmodule

`default_nettype wire

>>> sim/channel_frame_deframer_checker.sv
// channel_frame_deframer_checker: watches both channels of the deframer, predicts every result
// beat from the accepted input bytes and compares it with what comes out on m_*
// depends on cfd_pkg
`timescale 1ns / 1ps

module channel_frame_deframer_checker #(
    parameter logic [16*8-1:0] STREAM_HEADER = '0   // header byte n sits at [8*n +: 8]
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [cfd_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [cfd_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] payload_byte, [23:8] frame_channel
    input  wire logic                              m_tlast,   // end_of_frame
    input  wire logic [cfd_pkg::OUT_USER_W-1:0]    m_tuser,   // [0] is_control, [1] header_error
    output int                                     fault_count,
    output int                                     beats_owed
);

    typedef enum logic [2:0] {
        P_HEADER,
        P_CHAN_LO,
        P_CHAN_HI,
        P_LEN_LO,
        P_LEN_HI,
        P_PAYLOAD,
        P_HALTED
    } rx_phase_e;

    typedef struct packed {
        logic [cfd_pkg::BYTE_W-1:0] data;
        logic [cfd_pkg::CHAN_W-1:0] channel;
        logic                       control;
        logic                       last;
        logic                       hdr_err;
    } out_beat_t;

    // header index at which the header is done; the index wraps at 16
    localparam logic [3:0] HDR_DONE = 4'(cfd_pkg::HDR_BYTES % 16);

    rx_phase_e                   phase_q;
    logic [3:0]                  hdr_pos;
    logic [cfd_pkg::CHAN_W-1:0]  chan_q;
    logic [cfd_pkg::LEN_W-1:0]   len_q;
    logic [cfd_pkg::LEN_W-1:0]   taken_q;
    out_beat_t                   owed_q[$];

    function automatic string show_beat(input out_beat_t b);
        return $sformatf("data %02h chan %04h ctrl %0b last %0b herr %0b",
                         b.data, b.channel, b.control, b.last, b.hdr_err);
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // advances the frame parser by one byte and queues the result beat it causes
    function automatic void track_rx(input logic [cfd_pkg::BYTE_W-1:0] b);
        out_beat_t r;
        r = '0;
        case (phase_q)
            P_HEADER: begin
                if (b != STREAM_HEADER[8*hdr_pos +: 8]) begin
                    r.hdr_err = 1'b1;
                    owed_q.push_back(r);
                    phase_q = P_HALTED;
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                    if (hdr_pos == HDR_DONE)
                        phase_q = P_CHAN_LO;
                end
            end
            P_CHAN_LO: begin
                chan_q = {8'h00, b};
                phase_q = P_CHAN_HI;
            end
            P_CHAN_HI: begin
                chan_q = {b, chan_q[7:0]};
                phase_q = P_LEN_LO;
            end
            P_LEN_LO: begin
                len_q = {8'h00, b};
                phase_q = P_LEN_HI;
            end
            P_LEN_HI: begin
                len_q = {b, len_q[7:0]};
                taken_q = '0;
                // an empty frame ends right here and emits nothing
                phase_q = (len_q == '0) ? P_CHAN_LO : P_PAYLOAD;
            end
            P_PAYLOAD: begin
                taken_q = taken_q + 1'b1;
                r.data = b;
                r.channel = chan_q;
                r.control = (chan_q == '0);
                r.last = (taken_q == len_q);
                owed_q.push_back(r);
                if (r.last) begin
                    taken_q = '0;
                    phase_q = P_CHAN_LO;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        out_beat_t got;
        out_beat_t want;
        if (!aresetn) begin
            phase_q = P_HEADER;
            hdr_pos = '0;
            chan_q = '0;
            len_q = '0;
            taken_q = '0;
            owed_q.delete();
        end else begin
            // a result can never come from the byte accepted at the same edge
            if (m_tvalid && m_tready) begin
                got.data = m_tdata[cfd_pkg::BYTE_W-1:0];
                got.channel = m_tdata[cfd_pkg::OUT_DATA_W-1:cfd_pkg::BYTE_W];
                got.control = m_tuser[cfd_pkg::USER_CTRL];
                got.last = m_tlast;
                got.hdr_err = m_tuser[cfd_pkg::USER_HERR];
                if (owed_q.size() == 0) begin
                    note_fault({"unexpected beat: ", show_beat(got)});
                end else begin
                    want = owed_q.pop_front();
                    if (got.data !== want.data || got.channel !== want.channel ||
                        got.control !== want.control || got.last !== want.last ||
                        got.hdr_err !== want.hdr_err)
                        note_fault({"expected ", show_beat(want), ", got ", show_beat(got)});
                end
            end
            if (s_tvalid && s_tready)
                track_rx(s_tdata);
        end
        beats_owed <= owed_q.size();
    end

endmodule

>>> sim/channel_frame_deframer_test.sv
// channel_frame_deframer_test: drives header and frame bytes into the deframer with random
// gaps and back-pressure; result checking lives in channel_frame_deframer_checker
// depends on cfd_pkg, channel_frame_deframer and channel_frame_deframer_checker
`timescale 1ns / 1ps

module channel_frame_deframer_test;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 1300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE       = 6;

    // "Xz 000.001\r\n", zero filled to 16 bytes, byte 0 lowest
    localparam logic [16*8-1:0] STREAM_HEADER = {
        32'h0000_0000, 8'h0A, 8'h0D, 8'h31, 8'h30, 8'h30, 8'h2E,
        8'h30, 8'h30, 8'h30, 8'h20, 8'h7A, 8'h58
    };

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [cfd_pkg::BYTE_W-1:0]         s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [cfd_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                               m_tlast;
    logic [cfd_pkg::OUT_USER_W-1:0]     m_tuser;

    int fault_count;
    int beats_owed;
    int sent_bytes;
    int tx_rate;
    bit hold_req;
    bit quiet;

    channel_frame_deframer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    channel_frame_deframer_checker #(
        .STREAM_HEADER (STREAM_HEADER)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fault_count (fault_count),
        .beats_owed  (beats_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic put_byte(input logic [cfd_pkg::BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 63) == 0)
            tx_rate = $urandom_range(0, 4);
        if (!quiet && tx_rate != 0 && $urandom_range(0, 7) < tx_rate) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_bytes++;
    endtask

    // channel then length, both little-endian
    task automatic frame_head(input logic [15:0] chan, input logic [15:0] len);
        put_byte(chan[7:0]);
        put_byte(chan[15:8]);
        put_byte(len[7:0]);
        put_byte(len[15:8]);
    endtask

    task automatic send_frame(input logic [15:0] chan, input logic [15:0] len);
        frame_head(chan, len);
        for (int i = 0; i < int'(len); i++)
            put_byte(8'($urandom));
    endtask

    task automatic wait_owed_clear();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_owed != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int stall;
        int rx_rate;
        rx_rate = 2;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                rx_rate = $urandom_range(0, 4);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else if (!quiet && rx_rate != 0 && $urandom_range(0, 7) < rx_rate) begin
                stall = $urandom_range(1, 7);
            end else begin
                stall = 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        int base;
        bit pressed;
        logic [15:0] chan;
        logic [15:0] len;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        tx_rate = 2;
        pressed = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < cfd_pkg::HDR_BYTES; i++)
            put_byte(STREAM_HEADER[8*(i % 16) +: 8]);

        // control channel, payload extremes
        frame_head(16'h0000, 16'h0002);
        put_byte(8'h00);
        put_byte(8'hFF);
        frame_head(16'hFFFF, 16'h0001);
        put_byte(8'hA5);
        // empty frame, then the next byte must start a fresh channel field
        frame_head(16'h8001, 16'h0000);
        frame_head(16'h0001, 16'h0001);
        put_byte(8'h5A);
        wait_owed_clear();

        base = sent_bytes;
        while (sent_bytes - base < RANDOM_BYTES) begin
            case ($urandom_range(0, 7))
                0:       chan = 16'h0000;
                1:       chan = 16'hFFFF;
                2:       chan = 16'($urandom_range(1, 3));
                default: chan = 16'($urandom);
            endcase
            case ($urandom_range(0, 19))
                0, 1:    len = 16'h0000;
                2:       len = 16'($urandom_range(255, 257));
                default: len = 16'($urandom_range(1, 12));
            endcase
            if (!pressed && sent_bytes - base >= RANDOM_BYTES / 2) begin
                // results back up while bytes keep coming, so the input must stall
                pressed = 1'b1;
                hold_req = 1'b1;
                len = 16'd256;
            end
            send_frame(chan, len);
        end
        wait_owed_clear();

        // last part: no idling, one longer frame at full rate
        quiet = 1'b1;
        send_frame(16'h5A3C, 16'd60);
        send_frame(16'h0000, 16'h0003);
        wait_owed_clear();
        repeat (SETTLE) @(posedge aclk);

        if (fault_count == 0 && beats_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
